// ===== rtl/adxfd_pkg.sv =====
`timescale 1ns / 1ps

package adxfd_pkg;

    localparam int DATA_W     = 8;
    localparam int COEF_W     = 15;
    localparam int SAMPLE_W   = 16;
    localparam int SCALE_W    = 17;
    localparam int POS_W      = 5;
    localparam int NIB_W      = 4;
    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 16;
    localparam int ACC_W      = 32;
    localparam int PRED_SHIFT = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [POS_W-1:0] POS_SCALE_HI = 5'd0;
    localparam logic [POS_W-1:0] POS_SCALE_LO = 5'd1;
    localparam logic [POS_W-1:0] POS_LAST     = 5'd17;

    localparam logic signed [ACC_W-1:0] SAMPLE_MAX = 32'sd32767;
    localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -32'sd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RECENT,
        ST_MUL_OLDER,
        ST_MUL_STEP,
        ST_SUM,
        ST_STORE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SHIFT_ADD
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_first;
        logic signed [COEF_W-1:0] coef_second;
        logic                     stereo_mode;
    } cfg_t;

endpackage

// ===== rtl/adxfd_ifs.sv =====
`timescale 1ns / 1ps

interface adxfd_byte_if;
    logic                             valid;
    logic                             ready;
    logic [adxfd_pkg::DATA_W-1:0]     data_byte;
    logic                             track_start;

    modport source (output valid, output data_byte, output track_start, input ready);
    modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface adxfd_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [adxfd_pkg::SAMPLE_W-1:0] sample_value;
    logic                                channel_index;
    logic                                frame_end;
    logic                                last_of_byte;

    modport source (output valid, output sample_value, output channel_index,
                    output frame_end, output last_of_byte, input ready);
    modport sink   (input valid, input sample_value, input channel_index,
                    input frame_end, input last_of_byte, output ready);
endinterface

interface adxfd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [adxfd_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [adxfd_pkg::COEF_W-1:0]        write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== rtl/adxfd_mac.sv =====
`timescale 1ns / 1ps

module adxfd_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  adxfd_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [adxfd_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [adxfd_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [adxfd_pkg::ACC_W-1:0]    acc
);

    localparam int PROD_W = adxfd_pkg::MUL_A_W + adxfd_pkg::MUL_B_W;

    logic signed [PROD_W-1:0]           prod_full;
    logic signed [adxfd_pkg::ACC_W-1:0] prod_reg;
    logic signed [adxfd_pkg::ACC_W-1:0] acc_reg;
    logic signed [adxfd_pkg::ACC_W-1:0] acc_next;

    assign prod_full = op_a * op_b;

    always_comb
    begin
        unique case (ctrl.acc_op)
            adxfd_pkg::ACC_LOAD:      acc_next = prod_reg;
            adxfd_pkg::ACC_ADD:       acc_next = acc_reg + prod_reg;
            adxfd_pkg::ACC_SHIFT_ADD: acc_next = (acc_reg >>> adxfd_pkg::PRED_SHIFT) + prod_reg;
            default:                  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.mul_en)
            begin
                prod_reg <= signed'(prod_full[adxfd_pkg::ACC_W-1:0]);
            end
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/adxfd_ctrl.sv =====
`timescale 1ns / 1ps

module adxfd_ctrl #(
    parameter int MAX_CHANNELS = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  adxfd_pkg::cfg_t                       cfg,
    adxfd_byte_if.sink                            byte_stream,
    adxfd_sample_if.source                        samples,
    output adxfd_pkg::mac_ctrl_t                  mac_ctrl,
    output logic signed [adxfd_pkg::MUL_A_W-1:0]  op_a,
    output logic signed [adxfd_pkg::MUL_B_W-1:0]  op_b,
    input  logic signed [adxfd_pkg::ACC_W-1:0]    acc
);

    localparam logic signed [adxfd_pkg::MUL_A_W-1:0] MUL_A_ZERO = '0;

    adxfd_pkg::state_t state_reg, state_next;

    logic signed [adxfd_pkg::SAMPLE_W-1:0] hist_recent_reg [MAX_CHANNELS];
    logic signed [adxfd_pkg::SAMPLE_W-1:0] hist_older_reg  [MAX_CHANNELS];
    logic [adxfd_pkg::POS_W-1:0]           pos_reg;
    logic [adxfd_pkg::POS_W-1:0]           pos_eff;
    logic                                  ch_reg;
    logic [adxfd_pkg::SCALE_W-1:0]         scale_reg;
    logic [adxfd_pkg::DATA_W-1:0]          byte_reg;
    logic                                  nib_sel_reg;

    logic                                  out_valid_reg;
    logic signed [adxfd_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                                  out_ch_reg;
    logic                                  out_end_reg;
    logic                                  out_last_reg;

    logic                                  accept;
    logic                                  out_free;
    logic                                  store;
    logic                                  is_last;
    logic [adxfd_pkg::NIB_W-1:0]           nibble;
    logic signed [adxfd_pkg::SAMPLE_W-1:0] sat_value;

    assign accept   = byte_stream.valid && byte_stream.ready;
    assign out_free = !out_valid_reg || samples.ready;
    assign pos_eff  = byte_stream.track_start ? adxfd_pkg::POS_SCALE_HI : pos_reg;
    assign is_last  = (pos_reg >= adxfd_pkg::POS_LAST);
    assign nibble   = nib_sel_reg ? byte_reg[3:0] : byte_reg[7:4];

    always_comb
    begin
        if (acc > adxfd_pkg::SAMPLE_MAX)
        begin
            sat_value = adxfd_pkg::SAMPLE_MAX[adxfd_pkg::SAMPLE_W-1:0];
        end
        else if (acc < adxfd_pkg::SAMPLE_MIN)
        begin
            sat_value = adxfd_pkg::SAMPLE_MIN[adxfd_pkg::SAMPLE_W-1:0];
        end
        else
        begin
            sat_value = acc[adxfd_pkg::SAMPLE_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            adxfd_pkg::ST_IDLE:
            begin
                if (byte_stream.valid && pos_eff != adxfd_pkg::POS_SCALE_HI
                    && pos_eff != adxfd_pkg::POS_SCALE_LO)
                begin
                    state_next = adxfd_pkg::ST_MUL_RECENT;
                end
            end
            adxfd_pkg::ST_MUL_RECENT: state_next = adxfd_pkg::ST_MUL_OLDER;
            adxfd_pkg::ST_MUL_OLDER:  state_next = adxfd_pkg::ST_MUL_STEP;
            adxfd_pkg::ST_MUL_STEP:   state_next = adxfd_pkg::ST_SUM;
            adxfd_pkg::ST_SUM:        state_next = adxfd_pkg::ST_STORE;
            adxfd_pkg::ST_STORE:
            begin
                if (out_free)
                begin
                    state_next = nib_sel_reg ? adxfd_pkg::ST_IDLE : adxfd_pkg::ST_MUL_RECENT;
                end
            end
            default: state_next = adxfd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        byte_stream.ready = 1'b0;
        store             = 1'b0;
        mac_ctrl.mul_en   = 1'b0;
        mac_ctrl.acc_op   = adxfd_pkg::ACC_HOLD;
        op_a              = MUL_A_ZERO;
        op_b              = '0;
        unique case (state_reg)
            adxfd_pkg::ST_IDLE:
            begin
                byte_stream.ready = 1'b1;
            end
            adxfd_pkg::ST_MUL_RECENT:
            begin
                mac_ctrl.mul_en = 1'b1;
                op_a            = adxfd_pkg::MUL_A_W'(cfg.coef_first);
                op_b            = hist_recent_reg[ch_reg];
            end
            adxfd_pkg::ST_MUL_OLDER:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = adxfd_pkg::ACC_LOAD;
                op_a            = adxfd_pkg::MUL_A_W'(cfg.coef_second);
                op_b            = hist_older_reg[ch_reg];
            end
            adxfd_pkg::ST_MUL_STEP:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = adxfd_pkg::ACC_ADD;
                op_a            = signed'({1'b0, scale_reg});
                op_b            = adxfd_pkg::MUL_B_W'(signed'(nibble));
            end
            adxfd_pkg::ST_SUM:
            begin
                mac_ctrl.acc_op = adxfd_pkg::ACC_SHIFT_ADD;
            end
            adxfd_pkg::ST_STORE:
            begin
                store = out_free;
            end
            default:
            begin
                byte_stream.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adxfd_pkg::ST_IDLE;
            pos_reg       <= adxfd_pkg::POS_SCALE_HI;
            ch_reg        <= 1'b0;
            scale_reg     <= '0;
            nib_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                hist_recent_reg[i] <= '0;
                hist_older_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                if (byte_stream.track_start)
                begin
                    ch_reg <= 1'b0;
                    for (int i = 0; i < MAX_CHANNELS; i++)
                    begin
                        hist_recent_reg[i] <= '0;
                        hist_older_reg[i]  <= '0;
                    end
                end
                if (pos_eff == adxfd_pkg::POS_SCALE_HI)
                begin
                    scale_reg <= {1'b0, byte_stream.data_byte, 8'h00};
                    pos_reg   <= adxfd_pkg::POS_SCALE_LO;
                end
                else if (pos_eff == adxfd_pkg::POS_SCALE_LO)
                begin
                    scale_reg <= {1'b0, scale_reg[15:8], byte_stream.data_byte}
                                 + adxfd_pkg::SCALE_W'(1);
                    pos_reg   <= pos_reg + adxfd_pkg::POS_W'(1);
                end
                else
                begin
                    nib_sel_reg <= 1'b0;
                end
            end

            if (store)
            begin
                hist_older_reg[ch_reg]  <= hist_recent_reg[ch_reg];
                hist_recent_reg[ch_reg] <= sat_value;
                nib_sel_reg             <= 1'b1;
                if (nib_sel_reg)
                begin
                    if (is_last)
                    begin
                        pos_reg <= adxfd_pkg::POS_SCALE_HI;
                        ch_reg  <= (MAX_CHANNELS > 1 && cfg.stereo_mode) ? ~ch_reg : 1'b0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + adxfd_pkg::POS_W'(1);
                    end
                end
            end

            if (store)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (samples.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_stream.data_byte;
        end
        if (store)
        begin
            out_sample_reg <= sat_value;
            out_ch_reg     <= ch_reg;
            out_end_reg    <= nib_sel_reg && is_last;
            out_last_reg   <= nib_sel_reg;
        end
    end

    assign samples.valid         = out_valid_reg;
    assign samples.sample_value  = out_sample_reg;
    assign samples.channel_index = out_ch_reg;
    assign samples.frame_end     = out_end_reg;
    assign samples.last_of_byte  = out_last_reg;

endmodule

// ===== rtl/adx_adpcm_frame_decoder_core.sv =====
// Scale bytes (frame positions 0 and 1) are accepted in idle and give no sample.
// A data byte is decoded a nibble at a time, high nibble first, on one shared multiplier
// (recent-history, older-history and step products, then sum and store); each nibble's
// store registers one sample. A store waits while the output is stalled, and no new
// byte is taken until the second sample of the current byte has been stored.
// rst_n is asynchronous active low; it clears coefficients, mode, histories and position.
`timescale 1ns / 1ps

module adx_adpcm_frame_decoder_core #(
    parameter int MAX_CHANNELS = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    adxfd_cfg_if.sink      cfg,
    adxfd_byte_if.sink     byte_stream,
    adxfd_sample_if.source samples
);

    adxfd_pkg::cfg_t                       cfg_reg;
    adxfd_pkg::mac_ctrl_t                  mac_ctrl;
    logic signed [adxfd_pkg::MUL_A_W-1:0]  op_a;
    logic signed [adxfd_pkg::MUL_B_W-1:0]  op_b;
    logic signed [adxfd_pkg::ACC_W-1:0]    acc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                adxfd_pkg::CFG_COEF_FIRST:  cfg_reg.coef_first  <= signed'(cfg.write_data);
                adxfd_pkg::CFG_COEF_SECOND: cfg_reg.coef_second <= signed'(cfg.write_data);
                adxfd_pkg::CFG_STEREO_MODE: cfg_reg.stereo_mode <= cfg.write_data[0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    adxfd_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .byte_stream (byte_stream),
        .samples     (samples),
        .mac_ctrl    (mac_ctrl),
        .op_a        (op_a),
        .op_b        (op_b),
        .acc         (acc)
    );

    adxfd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

endmodule
